>>> rtl/imu_pkg.sv
// shared types and constants for the ising metropolis update block
// no dependencies; imported by imu_ctrl, imu_datapath, ising_metropolis_update and the testbench
package imu_pkg;

   // lattice geometry
   localparam int SIDE   = 8;
   localparam int SITES  = SIDE * SIDE;
   localparam int SITE_W = 6;

   // datapath widths
   localparam int ENERGY_W     = 9;
   localparam int OUT_ENERGY_W = 8;
   localparam int NSUM_W       = 4;
   localparam int THR_W        = 16;
   localparam int RND_W        = 16;
   localparam int THR_COUNT    = 4;
   localparam int THR_IDX_W    = 2;
   localparam int CSR_IDX_W    = 2;

   // energy of the all-minus lattice, every bond contributes one
   localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(2 * SIDE * (SIDE - 1));

   // operation codes
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_ATTEMPT = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THR_TWO   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_FOUR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_SIX   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_EIGHT = 2'd3;

   // threshold reset values, fractions of exp(-delta/T)
   localparam logic [THR_W-1:0] THR_RESET [THR_COUNT] = '{16'd24109, 16'd8869, 16'd3263, 16'd1200};

   // which lattice site a read targets
   typedef enum logic [2:0] {
      DIR_CENTER,
      DIR_UP,
      DIR_DOWN,
      DIR_LEFT,
      DIR_RIGHT
   } dir_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic    capture;
      logic    issue;
      dir_type dir;
      logic    commit;
   } cmd_type;

endpackage

>>> rtl/imu_ctrl.sv
// controller state machine of the ising metropolis update block
// sequences the five spin reads, the commit and the response slot; uses imu_pkg
module imu_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output imu_pkg::cmd_type cmd
);
   import imu_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_WAIT,
      S_COMMIT
   } state_type;

   state_type state_ff, state_in;
   dir_type   dir_ff, dir_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      commit_go;

   // commit only when the response slot is free or being drained
   assign commit_go = (state_ff == S_COMMIT) && (!rsp_valid_ff || rsp_tready);

   // handshake and command outputs
   always_comb begin
      req_tready  = (state_ff == S_IDLE);
      rsp_tvalid  = rsp_valid_ff;
      cmd.capture = (state_ff == S_IDLE) && req_tvalid;
      cmd.issue   = (state_ff == S_READ);
      cmd.dir     = dir_ff;
      cmd.commit  = commit_go;
   end

   // next state and read direction
   always_comb begin
      state_in     = state_ff;
      dir_in       = dir_ff;
      rsp_valid_in = rsp_valid_ff;
      if (commit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_READ;
               dir_in   = DIR_CENTER;
            end
         end
         S_READ: begin
            case (dir_ff)
               DIR_CENTER: dir_in = DIR_UP;
               DIR_UP:     dir_in = DIR_DOWN;
               DIR_DOWN:   dir_in = DIR_LEFT;
               DIR_LEFT:   dir_in = DIR_RIGHT;
               default:    state_in = S_WAIT;
            endcase
         end
         S_WAIT: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (commit_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dir_ff       <= DIR_CENTER;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/imu_datapath.sv
// datapath of the ising metropolis update block: spin memory, neighbor sum,
// energy register, thresholds and response payload; uses imu_pkg
module imu_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  imu_pkg::cmd_type                 cmd,
   input  logic                             req_operation,
   input  logic [imu_pkg::SITE_W-1:0]       req_site,
   input  logic                             req_spin_value,
   input  logic [imu_pkg::RND_W-1:0]        req_random_fraction,
   input  logic                             csr_write,
   input  logic [imu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [imu_pkg::THR_W-1:0]        csr_data,
   output logic [imu_pkg::OUT_ENERGY_W-1:0] rsp_energy,
   output logic                             rsp_accepted,
   output logic                             rsp_spin_after
);
   import imu_pkg::*;

   // captured request
   logic              op_ff;
   logic [SITE_W-1:0] site_ff;
   logic              newbit_ff;
   logic [RND_W-1:0]  rnd_ff;

   // spin memory, valid bits stand for the all-minus reset
   logic             spin_mem [SITES];
   logic [SITES-1:0] valid_ff;
   logic             mem_q_ff, vld_q_ff;
   logic             rd_bit;

   // read tracking and accumulation
   logic                     rd_pend_ff;
   dir_type                  rd_dir_ff;
   logic                     rd_exist_ff;
   logic signed [NSUM_W-1:0] nsum_ff;
   logic                     center_ff;

   logic signed [ENERGY_W-1:0] energy_ff;
   logic [THR_W-1:0]           thr_ff [THR_COUNT];

   logic [OUT_ENERGY_W-1:0] energy_out_ff;
   logic                    acc_out_ff, spin_out_ff;

   // neighbor addressing
   logic [SITE_W-1:0] col;
   logic [SITE_W:0]   site_ext;
   logic              has_up, has_down, has_left, has_right, in_range;
   logic [SITE_W-1:0] rd_addr;
   logic              rd_exist;

   // commit decision
   logic signed [ENERGY_W-1:0] n2, flip_delta, delta;
   logic [NSUM_W-1:0]          nmag;
   logic [THR_IDX_W-1:0]       thr_idx;
   logic                       keep, wr_en, new_spin, acc, spin_after;
   logic signed [ENERGY_W-1:0] energy_next;

   // which neighbors exist at the edges
   always_comb begin
      site_ext  = {1'b0, site_ff};
      col       = SITE_W'(site_ff % SIDE);
      in_range  = site_ext < (SITE_W + 1)'(SITES);
      has_up    = site_ext >= (SITE_W + 1)'(SIDE);
      has_down  = (site_ext + (SITE_W + 1)'(SIDE)) < (SITE_W + 1)'(SITES);
      has_left  = col != '0;
      has_right = col != SITE_W'(SIDE - 1);
   end

   // read address for the current step, clamped to the site when absent
   always_comb begin
      rd_addr  = site_ff;
      rd_exist = 1'b0;
      case (cmd.dir)
         DIR_CENTER: begin
            rd_exist = 1'b1;
         end
         DIR_UP: begin
            rd_exist = has_up;
            if (has_up) rd_addr = site_ff - SITE_W'(SIDE);
         end
         DIR_DOWN: begin
            rd_exist = has_down;
            if (has_down) rd_addr = site_ff + SITE_W'(SIDE);
         end
         DIR_LEFT: begin
            rd_exist = has_left;
            if (has_left) rd_addr = site_ff - SITE_W'(1);
         end
         DIR_RIGHT: begin
            rd_exist = has_right;
            if (has_right) rd_addr = site_ff + SITE_W'(1);
         end
         default: begin
            rd_exist = 1'b0;
         end
      endcase
   end

   assign rd_bit = mem_q_ff & vld_q_ff;

   // energy change and acceptance
   always_comb begin
      n2          = {{(ENERGY_W - NSUM_W - 1){nsum_ff[NSUM_W-1]}}, nsum_ff, 1'b0};
      flip_delta  = center_ff ? -n2 : n2;
      nmag        = nsum_ff[NSUM_W-1] ? NSUM_W'(-nsum_ff) : NSUM_W'(nsum_ff);
      thr_idx     = THR_IDX_W'(nmag - NSUM_W'(1));
      keep        = (flip_delta <= 0) || (rnd_ff < thr_ff[thr_idx]);
      wr_en       = 1'b0;
      new_spin    = center_ff;
      delta       = '0;
      acc         = 1'b0;
      case (op_ff)
         OP_LOAD: begin
            wr_en    = 1'b1;
            new_spin = newbit_ff;
            delta    = (newbit_ff == center_ff) ? '0 : flip_delta;
         end
         OP_ATTEMPT: begin
            wr_en    = keep;
            new_spin = ~center_ff;
            delta    = keep ? flip_delta : '0;
            acc      = keep;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
      if (!in_range) begin
         wr_en = 1'b0;
         delta = '0;
         acc   = 1'b0;
      end
      spin_after  = in_range & (wr_en ? new_spin : center_ff);
      energy_next = energy_ff + delta;
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_operation;
         site_ff   <= req_site;
         newbit_ff <= req_spin_value;
         rnd_ff    <= req_random_fraction;
      end
      if (cmd.commit) begin
         energy_out_ff <= energy_next[OUT_ENERGY_W-1:0];
         acc_out_ff    <= acc;
         spin_out_ff   <= spin_after;
      end
   end

   // spin memory, one read and one write port
   always_ff @(posedge clock) begin
      mem_q_ff <= spin_mem[rd_addr];
      if (cmd.commit && wr_en) begin
         spin_mem[site_ff] <= new_spin;
      end
   end

   // valid bits, read along with the memory
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_q_ff <= 1'b0;
      end else begin
         vld_q_ff <= valid_ff[rd_addr];
         if (cmd.commit && wr_en) begin
            valid_ff[site_ff] <= 1'b1;
         end
      end
   end

   // read tracking, neighbor sum and center spin
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff  <= 1'b0;
         rd_dir_ff   <= DIR_CENTER;
         rd_exist_ff <= 1'b0;
         nsum_ff     <= '0;
         center_ff   <= 1'b0;
      end else begin
         rd_pend_ff  <= cmd.issue;
         rd_dir_ff   <= cmd.dir;
         rd_exist_ff <= rd_exist;
         if (cmd.capture) begin
            nsum_ff <= '0;
         end else if (rd_pend_ff) begin
            if (rd_dir_ff == DIR_CENTER) begin
               center_ff <= rd_bit;
            end else if (rd_exist_ff) begin
               nsum_ff <= rd_bit ? nsum_ff + NSUM_W'(1) : nsum_ff - NSUM_W'(1);
            end
         end
      end
   end

   // energy register and thresholds
   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff <= ENERGY_RESET;
         thr_ff    <= THR_RESET;
      end else begin
         if (cmd.commit) begin
            energy_ff <= energy_next;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_THR_TWO:   thr_ff[0] <= csr_data;
               CSR_THR_FOUR:  thr_ff[1] <= csr_data;
               CSR_THR_SIX:   thr_ff[2] <= csr_data;
               CSR_THR_EIGHT: thr_ff[3] <= csr_data;
               default:       thr_ff[0] <= thr_ff[0];
            endcase
         end
      end
   end

   assign rsp_energy     = energy_out_ff;
   assign rsp_accepted   = acc_out_ff;
   assign rsp_spin_after = spin_out_ff;

endmodule

>>> rtl/ising_metropolis_update.sv
// Metropolis update engine for an 8 x 8 Ising lattice with open edges.
// Request channel (req_): tuser selects load (0) or flip attempt (1), tdata
// carries site, spin to load and a 16-bit random fraction. Each request gives
// exactly one response (rsp_) with the lattice energy after it, the accepted
// flag and the spin at the site afterwards.
// Configuration (csr_): four 16-bit acceptance thresholds, indexes 0 to 3 for
// energy rises of two, four, six and eight; csr_ready is always high. Write
// them only while no request is in flight.
// Timing: one request is in flight at a time. The single read port of the
// spin memory reads the site and its four neighbors one per cycle; a wait
// step follows, then the commit loads the response register. The response
// register frees the engine only when it is empty or being drained: a
// stalled rsp_tready holds the response stable and the request in flight
// waits in its final step.
// Reset (synchronous, active high) sets every spin to minus one, the energy
// to 112 and the thresholds to their defaults; it takes effect at once with
// no clearing pass.
// uses imu_pkg, imu_ctrl and imu_datapath
module ising_metropolis_update (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,  // site, spin_value, random_fraction
   input  logic                           req_tuser,  // operation
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,  // energy, accepted, spin_after
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [imu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [imu_pkg::THR_W-1:0]      csr_data
);
   import imu_pkg::*;

   cmd_type                 cmd;
   logic [OUT_ENERGY_W-1:0] rsp_energy;
   logic                    rsp_accepted, rsp_spin_after;

   assign csr_ready = 1'b1;

   // controller
   imu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // datapath
   imu_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_operation       (req_tuser),
      .req_site            (req_tdata[5:0]),
      .req_spin_value      (req_tdata[6]),
      .req_random_fraction (req_tdata[22:7]),
      .csr_write           (csr_valid & csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_energy          (rsp_energy),
      .rsp_accepted        (rsp_accepted),
      .rsp_spin_after      (rsp_spin_after)
   );

   // response packing
   assign rsp_tdata = {6'd0, rsp_spin_after, rsp_accepted, rsp_energy};

endmodule

>>> rtl/imu_checker.sv
// port-level checks for the ising metropolis update block
// bound to ising_metropolis_update; no other dependencies
module imu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // reset leaves no response pending
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // one request at a time: ready drops after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while one is in flight");

   // bond count is even, so the energy stays even
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[0])
      else $error("odd lattice energy");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind ising_metropolis_update imu_checker u_imu_checker (.*);

>>> tb/sv/ising_metropolis_update_tb.sv
// Self-checking testbench for the ising metropolis update block: a directed
// table followed by random requests, each response checked against a predictor or a table entry.
// Depends on imu_pkg and ising_metropolis_update.
`timescale 1ns / 100ps

module ising_metropolis_update_tb;
   import imu_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES    = 150;
   localparam int RANDOM_PER_SET = 66;
   localparam int SETTLE_CYCLES  = 12;

   // one response as the block reports it
   typedef struct packed {
      logic [7:0] energy;
      logic       accepted;
      logic       spin_after;
   } update_type;

   // one row of the directed table; want is used only where typed is set
   typedef struct packed {
      logic        op;
      logic [5:0]  site;
      logic        spin;
      logic [15:0] rnd;
      logic        typed;
      update_type  want;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 22;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // after reset: corner flip lowers the energy by four
      '{OP_ATTEMPT, 6'd0,  1'b0, 16'd0,     1'b1, '{8'd108, 1'b1, 1'b1}},
      '{OP_LOAD,    6'd0,  1'b0, 16'd0,     1'b1, '{8'd112, 1'b0, 1'b0}},
      // load of the spin already there
      '{OP_LOAD,    6'd0,  1'b0, 16'd65535, 1'b1, '{8'd112, 1'b0, 1'b0}},
      '{OP_LOAD,    6'd63, 1'b1, 16'd0,     1'b1, '{8'd108, 1'b0, 1'b1}},
      // rise of four, fraction at its top is rejected
      '{OP_ATTEMPT, 6'd63, 1'b0, 16'd65535, 1'b1, '{8'd108, 1'b0, 1'b1}},
      '{OP_ATTEMPT, 6'd63, 1'b0, 16'd0,     1'b1, '{8'd112, 1'b1, 1'b0}},
      // interior site, then rise of eight on both sides of its threshold
      '{OP_ATTEMPT, 6'd27, 1'b0, 16'd0,     1'b0, '0},
      '{OP_ATTEMPT, 6'd27, 1'b0, 16'd1200,  1'b0, '0},
      '{OP_ATTEMPT, 6'd27, 1'b0, 16'd1199,  1'b0, '0},
      // edge site, rise of six around its threshold
      '{OP_ATTEMPT, 6'd3,  1'b0, 16'd65535, 1'b0, '0},
      '{OP_ATTEMPT, 6'd3,  1'b0, 16'd3263,  1'b0, '0},
      '{OP_ATTEMPT, 6'd3,  1'b0, 16'd3262,  1'b0, '0},
      // edge site with one plus neighbor gives a rise of two
      '{OP_LOAD,    6'd2,  1'b1, 16'd0,     1'b0, '0},
      '{OP_ATTEMPT, 6'd3,  1'b0, 16'd0,     1'b0, '0},
      '{OP_ATTEMPT, 6'd3,  1'b0, 16'd24109, 1'b0, '0},
      '{OP_ATTEMPT, 6'd3,  1'b0, 16'd24108, 1'b0, '0},
      // balanced neighbors: zero delta always kept
      '{OP_LOAD,    6'd19, 1'b1, 16'd0,     1'b0, '0},
      '{OP_LOAD,    6'd26, 1'b1, 16'd0,     1'b0, '0},
      '{OP_ATTEMPT, 6'd27, 1'b0, 16'd65535, 1'b0, '0},
      '{OP_ATTEMPT, 6'd27, 1'b0, 16'd65535, 1'b0, '0},
      // bottom-left and top-right corners
      '{OP_LOAD,    6'd56, 1'b1, 16'd65535, 1'b0, '0},
      '{OP_ATTEMPT, 6'd7,  1'b1, 16'd8868,  1'b0, '0}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // site, spin_value, random_fraction
   logic        req_tuser = 1'b0; // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // energy, accepted, spin_after
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [THR_W-1:0]     csr_data = '0;

   // shadow copy of the lattice, energy and thresholds
   logic        shadow_spin [SITES];
   int          shadow_energy;
   logic [15:0] shadow_thr [4];

   update_type pending_updates [$];
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      rcv_idle_pct = 0;
   bit      rsp_hold_request = 1'b0;
   int      idle_cycles = 0;

   ising_metropolis_update dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int spin_sign(int idx);
      return shadow_spin[idx] ? 1 : -1;
   endfunction

   // energy, acceptance and spin after one request, updating the shadow state
   function automatic update_type predict_update(logic op, logic [5:0] site, logic spin,
                                                 logic [15:0] rnd);
      update_type res;
      int      s;
      int      nsum;
      int      delta;
      int      row;
      int      col;
      int      k;
      logic    keep;
      row  = site / SIDE;
      col  = site % SIDE;
      s    = spin_sign(site);
      nsum = 0;
      if (row > 0) nsum += spin_sign(site - SIDE);
      if (row + 1 < SIDE) nsum += spin_sign(site + SIDE);
      if (col > 0) nsum += spin_sign(site - 1);
      if (col + 1 < SIDE) nsum += spin_sign(site + 1);
      res.accepted = 1'b0;
      if (op == OP_LOAD) begin
         shadow_energy += ((spin ? 1 : -1) - s) * nsum;
         shadow_spin[site] = spin;
      end else begin
         delta = -2 * s * nsum;
         if (delta <= 0) begin
            keep = 1'b1;
         end else begin
            k    = (delta / 2 - 1) & 3;
            keep = rnd < shadow_thr[k];
         end
         if (keep) begin
            shadow_energy += delta;
            shadow_spin[site] = ~shadow_spin[site];
            res.accepted = 1'b1;
         end
      end
      res.energy     = 8'(shadow_energy);
      res.spin_after = shadow_spin[site];
      return res;
   endfunction

   // offer one request, idling first at the current rate
   task automatic send_request(logic op, logic [5:0] site, logic spin, logic [15:0] rnd,
                               logic typed, update_type want);
      update_type pred;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, rnd, spin, site};
      do @(posedge clock); while (!req_tready);
      pred = predict_update(op, site, spin, rnd);
      pending_updates.push_back(typed ? want : pred);
   endtask

   task automatic send_random_request();
      logic        op;
      logic [15:0] rnd;
      int          k;
      op = ($urandom_range(0, 3) != 0) ? OP_ATTEMPT : OP_LOAD;
      k  = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
         0: begin
            rnd = shadow_thr[k] + 16'($urandom_range(0, 2)) - 16'd1;
         end
         1: begin
            rnd = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         end
         default: begin
            rnd = 16'($urandom_range(0, 65535));
         end
      endcase
      send_request(op, 6'($urandom_range(0, SITES - 1)), 1'($urandom_range(0, 1)), rnd,
                   1'b0, '0);
   endtask

   task automatic drain_updates();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [THR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      shadow_thr[idx] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // new threshold set, written only with nothing in flight
   task automatic apply_thresholds(logic [15:0] t2, logic [15:0] t4, logic [15:0] t6,
                                   logic [15:0] t8);
      drain_updates();
      write_csr(CSR_THR_TWO, t2);
      write_csr(CSR_THR_FOUR, t4);
      write_csr(CSR_THR_SIX, t6);
      write_csr(CSR_THR_EIGHT, t8);
   endtask

   function automatic logic [15:0] pick_threshold();
      case ($urandom_range(0, 2))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // response side: random stalls plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            hold_left = HOLD_CYCLES;
            rsp_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      update_type exp_upd;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_updates.size() == 0) begin
            $error("response with none pending: tdata=%h", rsp_tdata);
            error_count++;
         end else begin
            exp_upd = pending_updates.pop_front();
            if (rsp_tdata[7:0] !== exp_upd.energy) begin
               $error("energy: expected %0d, actual %0d", $signed(exp_upd.energy),
                      $signed(rsp_tdata[7:0]));
               error_count++;
            end
            if (rsp_tdata[8] !== exp_upd.accepted) begin
               $error("accepted: expected %0b, actual %0b", exp_upd.accepted, rsp_tdata[8]);
               error_count++;
            end
            if (rsp_tdata[9] !== exp_upd.spin_after) begin
               $error("spin_after: expected %0b, actual %0b", exp_upd.spin_after,
                      rsp_tdata[9]);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // main sequence
   initial begin
      for (int i = 0; i < SITES; i++) shadow_spin[i] = 1'b0;
      shadow_energy = 2 * SIDE * (SIDE - 1);
      shadow_thr[0] = 16'd24109;
      shadow_thr[1] = 16'd8869;
      shadow_thr[2] = 16'd3263;
      shadow_thr[3] = 16'd1200;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table at the reset thresholds
      send_idle_pct = 33;
      rcv_idle_pct  = 69;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_request(DIRECTED[i].op, DIRECTED[i].site, DIRECTED[i].spin, DIRECTED[i].rnd,
                      DIRECTED[i].typed, DIRECTED[i].want);
      end

      // random sets: two per idling mode
      for (int set = 0; set < 6; set++) begin
         case (set)
            0: apply_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            1: apply_thresholds(16'h0000, 16'h0000, 16'h0000, 16'h0000);
            3: apply_thresholds(16'd24109, 16'd8869, 16'd3263, 16'd1200);
            default: apply_thresholds(pick_threshold(), pick_threshold(), pick_threshold(),
                                      pick_threshold());
         endcase
         case (set / 2)
            0: begin
               send_idle_pct = 33;
               rcv_idle_pct  = 69;
            end
            1: begin
               send_idle_pct = 69;
               rcv_idle_pct  = 33;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
            end
         endcase
         for (int n = 0; n < RANDOM_PER_SET; n++) begin
            // long response hold-off while requests keep coming
            if (set == 4 && n == 5) rsp_hold_request = 1'b1;
            // sender pause until every response is back
            if (set == 1 && n == RANDOM_PER_SET / 2) begin
               @(negedge clock);
               req_tvalid <= 1'b0;
               while (pending_updates.size() != 0) @(posedge clock);
            end
            send_random_request();
         end
      end

      drain_updates();
      if (error_count == 0 && pending_updates.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
